/* sv/median_of_sample_set_core_macros.svh */
// Assertion helpers for the median core. All are clocked on aclk and
// disabled while aresetn is low.
`ifndef MEDIAN_OF_SAMPLE_SET_CORE_MACROS_SVH
`define MEDIAN_OF_SAMPLE_SET_CORE_MACROS_SVH

// Property that must hold at every edge.
`define MSOS_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Same-cycle implication.
`define MSOS_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MSOS_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/msos_pkg.sv */
package msos_pkg;

    localparam int CAPACITY = 256;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = SAMPLE_W + 1;
    localparam int M_DATA_W = ((MEDIAN_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // kind codes on the input tuser
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_FINAL  = 2'd1;
    localparam logic [1:0] KIND_CLOSE  = 2'd2;

    // status codes on the output tuser
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    // broadcast to every cell
    typedef struct packed {
        logic                       insert;
        logic                       shift;
        logic signed [SAMPLE_W-1:0] value;
    } cell_cmd_t;

    // per-cell position relative to the fill level
    typedef struct packed {
        logic valid;
        logic tail;
    } cell_pos_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic                       gt;
        logic signed [SAMPLE_W-1:0] value;
    } cell_link_t;

endpackage

/* sv/msos_cell.sv */
module msos_cell (
    input  logic                                aclk,
    input  msos_pkg::cell_cmd_t                 cmd,
    input  msos_pkg::cell_pos_t                 pos,
    input  msos_pkg::cell_link_t                left,
    input  logic signed [msos_pkg::SAMPLE_W-1:0] right_value,
    output msos_pkg::cell_link_t                link
);

    logic signed [msos_pkg::SAMPLE_W-1:0] value_reg;
    logic signed [msos_pkg::SAMPLE_W-1:0] value_next;
    logic                                 gt;

    assign gt         = pos.valid && (value_reg > cmd.value);
    assign link.gt    = gt;
    assign link.value = value_reg;

    // larger entries move up one place; the first of them takes the new word
    always_comb begin
        value_next = value_reg;
        if (cmd.insert && (gt || pos.tail)) begin
            value_next = left.gt ? left.value : cmd.value;
        end else if (cmd.shift) begin
            value_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

/* sv/median_of_sample_set_core.sv */
// Median of a sample set, result given as twice the median so it stays exact.
//
// Input channel (s_*): one word per sample. s_tuser is the kind: sample,
// final sample of the set, or close without a sample (kind 3 is taken and
// ignored). s_tdata is a signed Q16.16 sample.
// Output channel (m_*): one word per closed set. m_tdata is twice the median
// (33-bit signed), m_tuser the status: ok, empty set, or overflow.
//
// Samples go into a row of CAPACITY compare-and-shift cells that keep the
// set sorted; each sample is placed in the cycle it is accepted, so samples
// stream at one per cycle. On close the row shifts down by (count-1)/2
// places, one per cycle, which brings the middle entries to cells 0 and 1.
// s_tready stays low after the closing word until the result is registered.
// Samples past CAPACITY are dropped and the result is marked overflow.
// The result sits in an output register: the next set loads while it waits,
// and only the next close holds off when the receiver stalls.
// Reset empties the set and clears overflow and m_tvalid; no sweep needed.
module median_of_sample_set_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // [31:0] sample
    input  logic [1:0]                      s_tuser,   // [1:0] kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [msos_pkg::M_DATA_W-1:0]   m_tdata,   // [32:0] median_twice, rest zero
    output logic [1:0]                      m_tuser    // [1:0] status
);

`include "median_of_sample_set_core_macros.svh"

    msos_pkg::state_t state_reg, state_next;

    logic [msos_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                          overflow_reg, overflow_next;
    logic [msos_pkg::IDX_W-1:0]    drain_left_reg, drain_left_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [msos_pkg::MEDIAN_W-1:0] median_reg, median_next;
    logic [1:0]                    status_reg, status_next;

    logic                          accept;
    logic                          has_sample;
    logic                          is_close;
    logic                          full;
    logic                          do_insert;
    logic [msos_pkg::CNT_W-1:0]    count_after;
    logic [msos_pkg::CNT_W-1:0]    count_less1;
    logic                          out_free;
    logic                          drain_done;
    logic [msos_pkg::MEDIAN_W-1:0] low_ext;
    logic [msos_pkg::MEDIAN_W-1:0] high_ext;
    logic [msos_pkg::MEDIAN_W-1:0] median_sum;

    msos_pkg::cell_cmd_t  cmd;
    msos_pkg::cell_link_t links [msos_pkg::CAPACITY];

    // ---------------------------------------------------------------
    // Input decode
    // ---------------------------------------------------------------
    assign accept     = s_tvalid && s_tready;
    assign has_sample = (s_tuser == msos_pkg::KIND_SAMPLE) || (s_tuser == msos_pkg::KIND_FINAL);
    assign is_close   = accept &&
                        ((s_tuser == msos_pkg::KIND_FINAL) || (s_tuser == msos_pkg::KIND_CLOSE));
    assign full       = (count_reg == msos_pkg::CAP_CNT);
    assign do_insert  = accept && has_sample && !full;
    assign count_after = count_reg + msos_pkg::CNT_W'(do_insert);
    assign count_less1 = count_after - msos_pkg::CNT_W'(1);

    assign out_free   = !m_tvalid_reg || m_tready;
    assign drain_done = (drain_left_reg == '0);

    // ---------------------------------------------------------------
    // Sorted row of cells
    // ---------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < msos_pkg::CAPACITY; gi++) begin : g_cell
            msos_pkg::cell_pos_t  pos;
            msos_pkg::cell_link_t left;
            logic signed [msos_pkg::SAMPLE_W-1:0] right_value;

            assign pos.valid = (msos_pkg::CNT_W'(gi) < count_reg);
            assign pos.tail  = (msos_pkg::CNT_W'(gi) == count_reg);

            if (gi == 0) begin : g_first
                assign left.gt    = 1'b0;
                assign left.value = '0;
            end else begin : g_inner
                assign left = links[gi-1];
            end

            if (gi == msos_pkg::CAPACITY - 1) begin : g_last
                assign right_value = links[gi].value;
            end else begin : g_mid
                assign right_value = links[gi+1].value;
            end

            msos_cell u_cell (
                .aclk        (aclk),
                .cmd         (cmd),
                .pos         (pos),
                .left        (left),
                .right_value (right_value),
                .link        (links[gi])
            );
        end
    endgenerate

    // ---------------------------------------------------------------
    // Control: next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            msos_pkg::ST_LOAD: begin
                if (is_close) begin
                    state_next = msos_pkg::ST_DRAIN;
                end
            end
            msos_pkg::ST_DRAIN: begin
                if (drain_done && out_free) begin
                    state_next = msos_pkg::ST_LOAD;
                end
            end
            default: state_next = msos_pkg::ST_LOAD;
        endcase
    end

    // ---------------------------------------------------------------
    // Control: outputs to the row and the input side
    // ---------------------------------------------------------------
    always_comb begin
        s_tready   = 1'b0;
        cmd.insert = 1'b0;
        cmd.shift  = 1'b0;
        cmd.value  = $signed(s_tdata);
        case (state_reg)
            msos_pkg::ST_LOAD: begin
                s_tready   = 1'b1;
                cmd.insert = do_insert;
            end
            msos_pkg::ST_DRAIN: begin
                cmd.shift = !drain_done;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Median from the two lowest cells after the walk
    // ---------------------------------------------------------------
    assign low_ext    = {links[0].value[msos_pkg::SAMPLE_W-1], links[0].value};
    assign high_ext   = {links[1].value[msos_pkg::SAMPLE_W-1], links[1].value};
    // odd count: middle entry twice; even: the two middle entries
    assign median_sum = low_ext + (count_reg[0] ? low_ext : high_ext);

    always_comb begin
        count_next      = count_reg;
        overflow_next   = overflow_reg;
        drain_left_next = drain_left_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        median_next     = median_reg;
        status_next     = status_reg;

        if (state_reg == msos_pkg::ST_LOAD) begin
            count_next = count_after;
            if (accept && has_sample && full) begin
                overflow_next = 1'b1;
            end
            if (is_close) begin
                // shifts that bring the lower middle entry to cell 0
                drain_left_next = (count_after == '0) ? '0
                                : msos_pkg::IDX_W'(count_less1 >> 1);
            end
        end else if (state_reg == msos_pkg::ST_DRAIN) begin
            if (!drain_done) begin
                drain_left_next = drain_left_reg - msos_pkg::IDX_W'(1);
            end else if (out_free) begin
                m_tvalid_next = 1'b1;
                if (count_reg == '0) begin
                    median_next = '0;
                    status_next = msos_pkg::STATUS_EMPTY;
                end else begin
                    median_next = median_sum;
                    status_next = overflow_reg ? msos_pkg::STATUS_OVERFLOW
                                               : msos_pkg::STATUS_OK;
                end
                count_next    = '0;
                overflow_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= msos_pkg::ST_LOAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        drain_left_reg <= drain_left_next;
        median_reg     <= median_next;
        status_reg     <= status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(msos_pkg::M_DATA_W - msos_pkg::MEDIAN_W){1'b0}}, median_reg};
    assign m_tuser  = status_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `MSOS_ASSERT(a_count_cap, count_reg <= msos_pkg::CAP_CNT, "fill count past capacity")
    `MSOS_NEXT(a_drain_keeps_count, state_reg == msos_pkg::ST_DRAIN, $stable(count_reg) || count_reg == '0, "fill count moved during drain")
    `MSOS_IMPLY(a_empty_zero, m_tvalid && m_tuser == msos_pkg::STATUS_EMPTY, median_reg == '0, "empty set with nonzero median")

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

// Streaming testbench for the median core.
// A queue of pending input words is filled up front; a clocked driver presents
// them on the s_ side and a clocked monitor checks m_ words against a predictor
// that keeps its own sorted copy of the open sample set.
module tb_top;

    // kind 3 has no name in the package: the core takes it and does nothing
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int TOTAL_WORDS    = 850;            // stimulus stops around here
    localparam int HOLD_AT_RESULT = 30;             // result count that starts the long stall
    localparam int LONG_HOLD      = 400;            // cycles of m_tready low
    localparam int DRAIN_CYCLES   = msos_pkg::CAPACITY / 2 + 16;  // worst close walk plus slack
    localparam longint LIMIT_NS   = 64'd4_000_000;  // far above worst case

    typedef struct packed {
        logic [1:0]                    kind;
        logic [msos_pkg::SAMPLE_W-1:0] sample;
    } in_word_t;

    typedef struct packed {
        logic signed [msos_pkg::MEDIAN_W-1:0] twice;
        logic [1:0]                           status;
    } median_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [31:0]                   s_tdata  = '0;
    logic [1:0]                    s_tuser  = msos_pkg::KIND_SAMPLE;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [msos_pkg::M_DATA_W-1:0] m_tdata;
    logic [1:0]                    m_tuser;

    median_of_sample_set_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] sample
        .s_tuser  (s_tuser),   // [1:0] kind
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [32:0] median_twice, rest zero
        .m_tuser  (m_tuser)    // [1:0] status
    );

    // ---------------------------------------------------------------------
    // Predictor state: the open set kept ascending, plus the dropped flag
    // ---------------------------------------------------------------------
    logic signed [msos_pkg::SAMPLE_W-1:0] held_sorted[$];
    bit                                   held_dropped;
    median_t                              medians_due[$];   // expected results, oldest first
    in_word_t                             pending_words[$]; // stimulus not yet driven

    int words_planned;
    int words_taken;
    int ignored_words;
    int sets_closed;
    int empty_sets;
    int overflow_sets;
    int results_seen;
    int fail_count;

    logic     in_fire  = 1'b0;   // input word taken at the last rising edge
    logic     out_fire = 1'b0;   // result taken at the last rising edge
    int       tx_gap;
    bit       tx_calm;
    int       rx_wait;
    bit       rx_calm;
    in_word_t next_word;
    median_t  due;

    // insertion sort, same order rule as the hardware chain
    function automatic void hold_sample(logic signed [msos_pkg::SAMPLE_W-1:0] v);
        int pos;
        if (held_sorted.size() >= msos_pkg::CAPACITY) begin
            held_dropped = 1'b1;
        end else begin
            pos = held_sorted.size();
            while (pos > 0 && held_sorted[pos-1] > v)
                pos--;
            held_sorted.insert(pos, v);
        end
    endfunction

    // close the set: twice the median, sum of middle pair for even counts
    function automatic void close_set_predict();
        median_t r;
        int      mid;
        longint  lo;
        longint  hi;
        if (held_sorted.size() == 0) begin
            r.twice  = '0;
            r.status = msos_pkg::STATUS_EMPTY;
            empty_sets++;
        end else begin
            mid = held_sorted.size() / 2;
            hi  = held_sorted[mid];
            if (held_sorted.size() % 2 == 0) begin
                lo = held_sorted[mid-1];
            end else begin
                lo = hi;
            end
            r.twice  = msos_pkg::MEDIAN_W'(lo + hi);
            r.status = held_dropped ? msos_pkg::STATUS_OVERFLOW : msos_pkg::STATUS_OK;
            if (held_dropped)
                overflow_sets++;
        end
        medians_due.push_back(r);
        sets_closed++;
        held_sorted.delete();
        held_dropped = 1'b0;
    endfunction

    function automatic void predict_word(logic [1:0] kind,
                                         logic [msos_pkg::SAMPLE_W-1:0] sample);
        case (kind)
            msos_pkg::KIND_SAMPLE: hold_sample(sample);
            msos_pkg::KIND_FINAL: begin
                hold_sample(sample);
                close_set_predict();
            end
            msos_pkg::KIND_CLOSE: close_set_predict();
            default:              ignored_words++;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        fail_count++;
        if (fail_count <= 30)
            $display("ERROR @%0t: %s want %h got %h", $time, what, want, got);
    endtask

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    // style 0: full range; 1: few whole values (lots of ties); 2: corner values
    function automatic logic [31:0] pick_sample(int style);
        logic [31:0] v;
        case (style)
            0: v = $urandom;
            1: v = 32'(int'($urandom_range(0, 15)) - 8) << 16;
            default: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0001;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic push_word(logic [1:0] kind, logic [31:0] sample);
        in_word_t w;
        w.kind   = kind;
        w.sample = sample;
        pending_words.push_back(w);
        if (kind != KIND_UNUSED)
            words_planned++;
    endtask

    // n samples; the last is a final sample when close_with_final is set and n > 0,
    // otherwise a separate close word ends the set. Kind 3 noise sprinkled in.
    task automatic push_set(int n, int style, bit close_with_final);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0)
                push_word(KIND_UNUSED, $urandom);
            push_word((close_with_final && i == n - 1) ? msos_pkg::KIND_FINAL
                                                       : msos_pkg::KIND_SAMPLE,
                      pick_sample(style));
        end
        if (!close_with_final || n == 0)
            push_word(msos_pkg::KIND_CLOSE, $urandom);
    endtask

    // ---------------------------------------------------------------------
    // Clock, reset, stimulus
    // ---------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        // empty set straight after reset
        push_word(msos_pkg::KIND_CLOSE, 32'h1234_5678);
        // one-sample sets at both extremes
        push_word(msos_pkg::KIND_FINAL, 32'h7FFF_FFFF);
        push_word(msos_pkg::KIND_FINAL, 32'h8000_0000);
        // largest and smallest possible doubled median
        push_word(msos_pkg::KIND_SAMPLE, 32'h7FFF_FFFF);
        push_word(msos_pkg::KIND_FINAL, 32'h7FFF_FFFF);
        push_word(msos_pkg::KIND_SAMPLE, 32'h8000_0000);
        push_word(msos_pkg::KIND_FINAL, 32'h8000_0000);
        // kind 3 alone must not make the set non-empty
        push_word(KIND_UNUSED, 32'hFFFF_FFFF);
        push_word(msos_pkg::KIND_CLOSE, 32'hFFFF_FFFF);
        // out-of-order arrivals, even count: -3, 0, 2, 5 -> 0 + 2
        push_word(msos_pkg::KIND_SAMPLE, 32'h0005_0000);
        push_word(msos_pkg::KIND_SAMPLE, 32'hFFFD_0000);
        push_word(msos_pkg::KIND_SAMPLE, 32'h0000_0000);
        push_word(msos_pkg::KIND_FINAL, 32'h0002_0000);
        // odd count with ties, close word carries junk data
        push_word(msos_pkg::KIND_SAMPLE, 32'hFFFF_FFFF);
        push_word(msos_pkg::KIND_SAMPLE, 32'h0000_0001);
        push_word(msos_pkg::KIND_SAMPLE, 32'hFFFF_FFFF);
        push_word(msos_pkg::KIND_CLOSE, 32'h0000_0000);
        // max + min, kind 3 in the middle of an open set
        push_word(msos_pkg::KIND_SAMPLE, 32'h7FFF_FFFF);
        push_word(msos_pkg::KIND_SAMPLE, 32'h8000_0000);
        push_word(KIND_UNUSED, 32'h0000_0000);
        push_word(msos_pkg::KIND_CLOSE, 32'hAAAA_5555);

        // store exactly full (final sample is the 256th), then overrun it
        push_set(msos_pkg::CAPACITY, 1, 1'b1);
        push_set(msos_pkg::CAPACITY + 4, 0, 1'b1);

        // mostly short sets, some mid-size ones
        while (words_planned < TOTAL_WORDS)
            push_set(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(0, 12),
                     $urandom_range(0, 2), 1'(($urandom_range(0, 1))));
    end

    // ---------------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------------
    // word taken: update the predictor
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            in_fire     <= 1'b1;
            words_taken <= words_taken + 1;
            predict_word(s_tuser, s_tdata);
        end else begin
            in_fire <= 1'b0;
        end
    end

    // driver: holds a word until taken, then idles for the gap drawn with it
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || in_fire)) begin
            if (tx_gap > 0 || pending_words.size() == 0) begin
                s_tvalid <= 1'b0;
                if (tx_gap > 0)
                    tx_gap--;
            end else begin
                next_word = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_word.kind;
                s_tdata  <= next_word.sample;
                if ($urandom_range(0, 31) == 0)
                    tx_calm = !tx_calm;
                tx_gap = tx_calm ? 0 : $urandom_range(0, 3);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Output side
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            out_fire     <= 1'b1;
            results_seen <= results_seen + 1;
            if (medians_due.size() == 0) begin
                report_mismatch("result with no set closed", '0, 64'(m_tdata));
            end else begin
                due = medians_due.pop_front();
                // padding above the 33-bit field must read zero
                if (m_tdata !== {{(msos_pkg::M_DATA_W - msos_pkg::MEDIAN_W){1'b0}},
                                 due.twice})
                    report_mismatch("median_twice", 64'(due.twice), 64'(m_tdata));
                if (m_tuser !== due.status)
                    report_mismatch("status", 64'(due.status), 64'(m_tuser));
            end
        end else begin
            out_fire <= 1'b0;
        end
    end

    // receiver: short random stalls per result, one long hold so the output
    // register fills and the next close backs up into s_tready
    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_fire) begin
                if ($urandom_range(0, 31) == 0)
                    rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 3);
                if (results_seen == HOLD_AT_RESULT)
                    rx_wait = LONG_HOLD;
            end
            if (rx_wait > 0) begin
                m_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // End of run
    // ---------------------------------------------------------------------
    initial begin
        @(posedge aresetn);
        do
            @(posedge aclk);
        while (pending_words.size() != 0 || s_tvalid || medians_due.size() != 0);
        // let any stray result show up
        repeat (DRAIN_CYCLES) @(posedge aclk);
        foreach (medians_due[i])
            report_mismatch("result never arrived", 64'(medians_due[i].twice), '0);
        $display("summary: %0d words taken (%0d of kind 3), %0d sets closed",
                 words_taken, ignored_words, sets_closed);
        $display("summary: %0d empty, %0d with dropped samples, %0d results, %0d errors",
                 empty_sets, overflow_sets, results_seen, fail_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("timeout: %0d words pending, %0d results due",
                 pending_words.size(), medians_due.size());
        $display("tb: failure");
        $finish;
    end

endmodule
